// ===== hdl/lscc_pkg.sv =====
// Shared types and constants for the largest strongly connected component block.
// Used by lscc_store, lscc_unit, lscc_ctrl and the top level; no dependencies.
`default_nettype none

package lscc_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int CFG_W        = 6;
    localparam int IN_DATA_W    = ((2 * VTX_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((VTX_W + 1 + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = CFG_W'(MAX_VERTICES);

    typedef logic [MAX_VERTICES-1:0] mask_t;
    typedef logic [VTX_W-1:0]        vtx_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_CL_START = 9'b000000010,
        ST_CL_SCAN  = 9'b000000100,
        ST_CL_UPD   = 9'b000001000,
        ST_CS_LOAD  = 9'b000010000,
        ST_CS_SCAN  = 9'b000100000,
        ST_CS_CMP   = 9'b001000000,
        ST_OUT      = 9'b010000000,
        ST_SPARE    = 9'b100000000
    } state_t;

    // sequencer -> datapath
    typedef struct packed {
        logic  best_clear;
        logic  cl_start;
        logic  cl_scan;
        logic  cl_upd;
        logic  cs_load;
        logic  cs_scan;
        logic  cs_cmp;
        vtx_t  u;
        vtx_t  v;
        mask_t lim;
    } ctrl_t;

    // datapath -> sequencer
    typedef struct packed {
        logic frontier_empty;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/largest_strongly_connected_component.sv =====
// Largest strongly connected component. Edge beats are taken one per cycle
// into a 32x32 adjacency bit matrix. After the beat with tlast, the block is
// busy: for each vertex v in use (n of them) it grows a reachable set with a
// single OR-accumulate unit that reads one adjacency row per cycle, in rounds
// until a round finds no new vertex; then it scans the reach rows to find the
// largest mutually reachable set (ties to the lowest vertex), and sends n
// result beats, one per cycle when m_axis_tready is high. The user must write
// vertex_count (0 reads as 1, above 32 as 32) only while the block is idle;
// the block itself does not enforce it.
// Depends on lscc_pkg, lscc_store, lscc_unit and lscc_ctrl.
`default_nettype none

module largest_strongly_connected_component (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_wr_en,
    input  wire  [lscc_pkg::CFG_W-1:0]           cfg_wr_data,   // vertex_count
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [lscc_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // source_vertex, target_vertex
    input  wire                                  s_axis_tuser,  // edge_valid
    input  wire                                  s_axis_tlast,  // last_edge
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [lscc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // vertex_index, in_largest
    output logic                                 m_axis_tlast   // last_vertex
);
    import lscc_pkg::*;

    ctrl_t   ctrl;
    status_t status;
    mask_t   adj_row;
    mask_t   reach_row;
    mask_t   reach_wdata;
    mask_t   best_set;
    vtx_t    edge_src;
    vtx_t    edge_dst;
    vtx_t    rd_addr;
    vtx_t    out_vertex;
    logic    edge_we;
    logic    adj_clear;
    logic    reach_we;

    assign edge_src = s_axis_tdata[VTX_W-1:0];
    assign edge_dst = s_axis_tdata[2*VTX_W-1:VTX_W];
    assign edge_we  = s_axis_tvalid && s_axis_tready && s_axis_tuser;

    // search loads the v row once, every other step reads the u row
    assign rd_addr = ctrl.cs_load ? ctrl.v : ctrl.u;

    lscc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_last     (s_axis_tlast),
        .in_ready    (s_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_last    (m_axis_tlast),
        .out_vertex  (out_vertex),
        .status      (status),
        .ctrl        (ctrl),
        .adj_clear   (adj_clear),
        .reach_we    (reach_we)
    );

    lscc_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .edge_we     (edge_we),
        .edge_src    (edge_src),
        .edge_dst    (edge_dst),
        .adj_clear   (adj_clear),
        .rd_addr     (rd_addr),
        .reach_we    (reach_we),
        .reach_addr  (ctrl.v),
        .reach_wdata (reach_wdata),
        .adj_row     (adj_row),
        .reach_row   (reach_row)
    );

    lscc_unit u_unit (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .adj_row     (adj_row),
        .reach_row   (reach_row),
        .status      (status),
        .reach_wdata (reach_wdata),
        .best_set    (best_set)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - VTX_W - 1){1'b0}}, best_set[out_vertex], out_vertex};

endmodule

`default_nettype wire

// ===== hdl/lscc_store.sv =====
// Adjacency bit matrix and reachability rows, one row read per cycle.
// Depends on lscc_pkg.
`default_nettype none

module lscc_store (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   edge_we,
    input  wire  lscc_pkg::vtx_t  edge_src,
    input  wire  lscc_pkg::vtx_t  edge_dst,
    input  wire                   adj_clear,
    input  wire  lscc_pkg::vtx_t  rd_addr,
    input  wire                   reach_we,
    input  wire  lscc_pkg::vtx_t  reach_addr,
    input  wire  lscc_pkg::mask_t reach_wdata,
    output logic [lscc_pkg::MAX_VERTICES-1:0] adj_row,
    output logic [lscc_pkg::MAX_VERTICES-1:0] reach_row
);
    import lscc_pkg::*;

    mask_t adj_reg   [MAX_VERTICES];
    mask_t reach_reg [MAX_VERTICES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else if (adj_clear)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else if (edge_we)
        begin
            adj_reg[edge_src][edge_dst] <= 1'b1;
        end
    end

    // rows are written before they are read, no reset needed
    always_ff @(posedge clk)
    begin
        if (reach_we)
        begin
            reach_reg[reach_addr] <= reach_wdata;
        end
    end

    assign adj_row   = adj_reg[rd_addr];
    assign reach_row = reach_reg[rd_addr];

endmodule

`default_nettype wire

// ===== hdl/lscc_unit.sv =====
// Shared mask unit: frontier OR-accumulate for the closure, and the
// mutual-reach scan with running size and best-set compare. Depends on lscc_pkg.
`default_nettype none

module lscc_unit (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire  lscc_pkg::ctrl_t   ctrl,
    input  wire  lscc_pkg::mask_t   adj_row,
    input  wire  lscc_pkg::mask_t   reach_row,
    output lscc_pkg::status_t       status,
    output logic [lscc_pkg::MAX_VERTICES-1:0] reach_wdata,
    output logic [lscc_pkg::MAX_VERTICES-1:0] best_set
);
    import lscc_pkg::*;

    mask_t visited_reg,  visited_next;
    mask_t frontier_reg, frontier_next;
    mask_t acc_reg,      acc_next;
    mask_t rowv_reg,     rowv_next;
    mask_t set_reg,      set_next;
    cnt_t  size_reg,     size_next;
    mask_t best_set_reg, best_set_next;
    cnt_t  best_size_reg, best_size_next;
    mask_t fresh;
    mask_t v_bit;

    assign fresh = acc_reg & ~visited_reg;
    assign v_bit = mask_t'(1) << ctrl.v;

    always_comb
    begin
        visited_next   = visited_reg;
        frontier_next  = frontier_reg;
        acc_next       = acc_reg;
        rowv_next      = rowv_reg;
        set_next       = set_reg;
        size_next      = size_reg;
        best_set_next  = best_set_reg;
        best_size_next = best_size_reg;

        if (ctrl.best_clear)
        begin
            best_set_next  = '0;
            best_size_next = '0;
        end
        if (ctrl.cl_start)
        begin
            visited_next  = v_bit;
            frontier_next = v_bit;
            acc_next      = '0;
        end
        if (ctrl.cl_scan && frontier_reg[ctrl.u])
        begin
            acc_next = acc_reg | (adj_row & ctrl.lim);
        end
        if (ctrl.cl_upd)
        begin
            frontier_next = fresh;
            visited_next  = visited_reg | fresh;
            acc_next      = '0;
        end
        if (ctrl.cs_load)
        begin
            rowv_next = reach_row;
            set_next  = '0;
            size_next = '0;
        end
        // u in the set when v reaches u and u reaches v
        if (ctrl.cs_scan && rowv_reg[ctrl.u] && reach_row[ctrl.v])
        begin
            set_next[ctrl.u] = 1'b1;
            size_next        = size_reg + cnt_t'(1);
        end
        // strict compare keeps the lowest vertex on ties
        if (ctrl.cs_cmp && (size_reg > best_size_reg))
        begin
            best_set_next  = set_reg;
            best_size_next = size_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg   <= '0;
            frontier_reg  <= '0;
            acc_reg       <= '0;
            rowv_reg      <= '0;
            set_reg       <= '0;
            size_reg      <= '0;
            best_set_reg  <= '0;
            best_size_reg <= '0;
        end
        else
        begin
            visited_reg   <= visited_next;
            frontier_reg  <= frontier_next;
            acc_reg       <= acc_next;
            rowv_reg      <= rowv_next;
            set_reg       <= set_next;
            size_reg      <= size_next;
            best_set_reg  <= best_set_next;
            best_size_reg <= best_size_next;
        end
    end

    assign status.frontier_empty = (fresh == '0);
    assign reach_wdata           = visited_reg;
    assign best_set              = best_set_reg;

endmodule

`default_nettype wire

// ===== hdl/lscc_ctrl.sv =====
// Sequencer: edge load, per-vertex closure rounds, component search and
// result beats; also holds the vertex count register. Depends on lscc_pkg.
`default_nettype none

module lscc_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_wr_en,
    input  wire  [lscc_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire                    in_valid,
    input  wire                    in_last,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic                   out_last,
    output lscc_pkg::vtx_t         out_vertex,
    input  wire  lscc_pkg::status_t status,
    output lscc_pkg::ctrl_t        ctrl,
    output logic                   adj_clear,
    output logic                   reach_we
);
    import lscc_pkg::*;

    state_t            state_reg, state_next;
    vtx_t              u_reg, u_next;
    vtx_t              v_reg, v_next;
    cnt_t              n_reg, n_next;
    mask_t             lim_reg, lim_next;
    logic [CFG_W-1:0]  vcount_reg;
    cnt_t              n_clamp;
    cnt_t              n_minus;
    vtx_t              last_idx;
    logic              u_at_end;
    logic              v_at_end;
    logic              in_beat;
    logic              best_clear;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VERTEX_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            vcount_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_clamp = cnt_t'(1);
        end
        else if (vcount_reg > CFG_W'(MAX_VERTICES))
        begin
            n_clamp = cnt_t'(MAX_VERTICES);
        end
        else
        begin
            n_clamp = cnt_t'(vcount_reg);
        end
    end

    assign n_minus  = n_reg - cnt_t'(1);
    assign last_idx = n_minus[VTX_W-1:0];
    assign u_at_end = (u_reg == last_idx);
    assign v_at_end = (v_reg == last_idx);
    assign in_beat  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        n_next     = n_reg;
        lim_next   = lim_reg;
        adj_clear  = 1'b0;
        reach_we   = 1'b0;
        best_clear = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && in_last)
                begin
                    n_next = n_clamp;
                    for (int i = 0; i < MAX_VERTICES; i++)
                    begin
                        lim_next[i] = (cnt_t'(i) < n_clamp);
                    end
                    v_next     = '0;
                    best_clear = 1'b1;
                    state_next = ST_CL_START;
                end
            end
            ST_CL_START:
            begin
                u_next     = '0;
                state_next = ST_CL_SCAN;
            end
            ST_CL_SCAN:
            begin
                if (u_at_end)
                begin
                    state_next = ST_CL_UPD;
                end
                else
                begin
                    u_next = u_reg + vtx_t'(1);
                end
            end
            ST_CL_UPD:
            begin
                u_next = '0;
                if (status.frontier_empty)
                begin
                    reach_we = 1'b1;
                    if (v_at_end)
                    begin
                        v_next     = '0;
                        state_next = ST_CS_LOAD;
                    end
                    else
                    begin
                        v_next     = v_reg + vtx_t'(1);
                        state_next = ST_CL_START;
                    end
                end
                else
                begin
                    state_next = ST_CL_SCAN;
                end
            end
            ST_CS_LOAD:
            begin
                u_next     = '0;
                state_next = ST_CS_SCAN;
            end
            ST_CS_SCAN:
            begin
                if (u_at_end)
                begin
                    state_next = ST_CS_CMP;
                end
                else
                begin
                    u_next = u_reg + vtx_t'(1);
                end
            end
            ST_CS_CMP:
            begin
                if (v_at_end)
                begin
                    v_next     = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    v_next     = v_reg + vtx_t'(1);
                    state_next = ST_CS_LOAD;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (v_at_end)
                    begin
                        adj_clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        v_next = v_reg + vtx_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            u_reg     <= '0;
            v_reg     <= '0;
            n_reg     <= cnt_t'(1);
            lim_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            u_reg     <= u_next;
            v_reg     <= v_next;
            n_reg     <= n_next;
            lim_reg   <= lim_next;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_OUT);
    assign out_last   = v_at_end;
    assign out_vertex = v_reg;

    assign ctrl.best_clear = best_clear;
    assign ctrl.cl_start   = (state_reg == ST_CL_START);
    assign ctrl.cl_scan    = (state_reg == ST_CL_SCAN);
    assign ctrl.cl_upd     = (state_reg == ST_CL_UPD);
    assign ctrl.cs_load    = (state_reg == ST_CS_LOAD);
    assign ctrl.cs_scan    = (state_reg == ST_CS_SCAN);
    assign ctrl.cs_cmp     = (state_reg == ST_CS_CMP);
    assign ctrl.u          = u_reg;
    assign ctrl.v          = v_reg;
    assign ctrl.lim        = lim_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides active together");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cl_scan || ctrl.cs_scan) |-> (cnt_t'(u_reg) < n_reg))
        else $error("scan index beyond vertex count");

    a_vertex_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (cnt_t'(v_reg) < n_reg))
        else $error("vertex index beyond vertex count");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> in_ready)
        else $error("not idle after final result beat");

    a_closure_store: assert property (@(posedge clk) disable iff (!rst_n)
        reach_we |-> ctrl.cl_upd && status.frontier_empty)
        else $error("reach row written outside closure end");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for largest_strongly_connected_component: directed graphs first,
// then random graphs under three idle patterns, checked against a bit-mask model.
// Depends on lscc_pkg and the block's RTL only.

module tb;

    import lscc_pkg::*;

    localparam int STALL_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        vtx_t vertex;
        logic member;
        logic is_last;
    } vertex_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]      cfg_wr_data   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // source_vertex, target_vertex
    logic                  s_axis_tuser  = 1'b0; // edge_valid
    logic                  s_axis_tlast  = 1'b0; // last_edge
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // vertex_index, in_largest
    logic                  m_axis_tlast;         // last_vertex

    mask_t          adj_rows [MAX_VERTICES];
    int             vertices_in_use = MAX_VERTICES;
    vertex_result_t pending_vertices [$];
    int             mismatch_count = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;

    largest_strongly_connected_component dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    initial
    begin
        foreach (adj_rows[i])
            adj_rows[i] = '0;
    end

    // Reachability closure per vertex, then the first strictly largest
    // mutually reachable set; queues one result per vertex in use.
    function automatic void predict_largest_component();
        mask_t          reach [MAX_VERTICES];
        mask_t          lim, seen, frontier, grown, members, best_members;
        int             best_size, size;
        vertex_result_t r;
        lim = '0;
        for (int i = 0; i < vertices_in_use; i++)
            lim[i] = 1'b1;
        for (int v = 0; v < vertices_in_use; v++)
        begin
            seen = '0;
            seen[v] = 1'b1;
            frontier = seen;
            while (frontier != '0)
            begin
                grown = '0;
                for (int u = 0; u < vertices_in_use; u++)
                    if (frontier[u])
                        grown |= adj_rows[u] & lim;
                frontier = grown & ~seen;
                seen |= frontier;
            end
            reach[v] = seen;
        end
        best_members = '0;
        best_size = 0;
        for (int v = 0; v < vertices_in_use; v++)
        begin
            members = '0;
            for (int u = 0; u < vertices_in_use; u++)
                if (reach[v][u] && reach[u][v])
                    members[u] = 1'b1;
            size = $countones(members);
            if (size > best_size)
            begin
                best_members = members;
                best_size = size;
            end
        end
        for (int v = 0; v < vertices_in_use; v++)
        begin
            r.vertex  = vtx_t'(v);
            r.member  = best_members[v];
            r.is_last = (v == vertices_in_use - 1);
            pending_vertices.push_back(r);
        end
        foreach (adj_rows[i])
            adj_rows[i] = '0;
    endfunction

    function automatic vtx_t pick_vertex();
        if ($urandom_range(0, 9) == 0)
            return vtx_t'($urandom_range(0, MAX_VERTICES - 1));
        return vtx_t'($urandom_range(0, vertices_in_use - 1));
    endfunction

    // Called between falling edges; returns at the rising edge that took the
    // beat, so tvalid stays up when the next beat follows at once.
    task automatic send_edge(input logic ev, input vtx_t src, input vtx_t dst,
                             input logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({dst, src});
        s_axis_tuser  <= ev;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (ev)
            adj_rows[src][dst] = 1'b1;
        if (last)
            predict_largest_component();
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_vertex_count(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        if (value == 0)
            vertices_in_use = 1;
        else if (value > MAX_VERTICES)
            vertices_in_use = MAX_VERTICES;
        else
            vertices_in_use = value;
    endtask

    // Reset count of 32, no edges; the one edge here has edge_valid low.
    task automatic test_empty_graph();
        send_edge(1'b0, 5'd31, 5'd31, 1'b1);
    endtask

    task automatic test_single_vertex();
        write_vertex_count(6'd1);
        send_edge(1'b1, 5'd0, 5'd0, 1'b1);
        write_vertex_count(6'd0);
        send_edge(1'b1, 5'd31, 5'd31, 1'b0);
        send_edge(1'b1, 5'd0, 5'd31, 1'b0);
        send_edge(1'b0, 5'd0, 5'd0, 1'b1);
    endtask

    // Two loops of two vertices each, equal in size: the one holding vertex 0 must win.
    task automatic test_tie_break();
        write_vertex_count(6'd63);
        send_edge(1'b1, 5'd31, 5'd0, 1'b0);
        send_edge(1'b1, 5'd0, 5'd31, 1'b0);
        send_edge(1'b1, 5'd5, 5'd6, 1'b0);
        send_edge(1'b1, 5'd6, 5'd5, 1'b0);
        send_edge(1'b1, 5'd7, 5'd7, 1'b1);
    endtask

    // A loop closed only through vertex 9 (unused at count 4) must not count;
    // the graphs after it check that the matrix was cleared.
    task automatic test_unused_vertices();
        write_vertex_count(6'd4);
        send_edge(1'b1, 5'd1, 5'd2, 1'b0);
        send_edge(1'b1, 5'd2, 5'd9, 1'b0);
        send_edge(1'b1, 5'd9, 5'd1, 1'b0);
        send_edge(1'b1, 5'd3, 5'd3, 1'b0);
        send_edge(1'b0, 5'd2, 5'd1, 1'b1);
        send_edge(1'b1, 5'd2, 5'd1, 1'b1);
        send_edge(1'b1, 5'd2, 5'd1, 1'b0);
        send_edge(1'b1, 5'd1, 5'd3, 1'b0);
        send_edge(1'b1, 5'd3, 5'd2, 1'b1);
    endtask

    // Graphs are mostly chains that often loop back to their head, so that
    // non-trivial components show up.
    task automatic test_random_graphs(input logic [CFG_W-1:0] count_a,
                                      input logic [CFG_W-1:0] count_b,
                                      input logic [CFG_W-1:0] count_c);
        logic [CFG_W-1:0] counts [3];
        int               sent, edges;
        vtx_t             src, dst, head, prev;
        logic             ev;
        counts = '{count_a, count_b, count_c};
        head = '0;
        prev = '0;
        foreach (counts[p])
        begin
            write_vertex_count(counts[p]);
            sent = 0;
            while (sent < 26)
            begin
                edges = $urandom_range(1, 12);
                for (int j = 0; j < edges; j++)
                begin
                    ev  = ($urandom_range(0, 9) != 0);
                    src = (j > 0 && $urandom_range(0, 2) != 0) ? prev : pick_vertex();
                    if (j == 0)
                        head = src;
                    dst = (j > 0 && $urandom_range(0, 3) == 0) ? head : pick_vertex();
                    send_edge(ev, src, dst, j == edges - 1);
                    prev = dst;
                end
                sent += edges;
            end
        end
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_vertices
        vertex_result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[VTX_W-1:0], m_axis_tdata[VTX_W], m_axis_tlast};
            if (pending_vertices.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result beat: vertex %0d member %0b last %0b",
                         $time, got.vertex, got.member, got.is_last);
            end
            else
            begin
                want = pending_vertices.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    $display("%0t: expected vertex %0d member %0b last %0b, got %0d %0b %0b",
                             $time, want.vertex, want.member, want.is_last,
                             got.vertex, got.member, got.is_last);
                end
            end
        end
    end

    // Ends the run if no beat moves on either side for too long.
    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL largest_strongly_connected_component");
        $finish;
    end

    initial
    begin
        send_idle_pct = 29;
        recv_idle_pct = 50;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_empty_graph();
        test_single_vertex();
        test_tie_break();
        test_unused_vertices();
        test_random_graphs(6'd6, 6'd33, 6'd3);
        send_idle_pct = 50;
        recv_idle_pct = 29;
        test_random_graphs(6'd10, 6'd2, 6'd32);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_graphs(6'd5, 6'd8, 6'd0);
        drain_results();
        if (mismatch_count == 0)
            $display("PASS largest_strongly_connected_component");
        else
            $display("FAIL largest_strongly_connected_component");
        $finish;
    end

endmodule
